[src/runtime_history_priority_table_assert.svh]
// Assertion macros shared by the runtime history table checkers.
`ifndef RUNTIME_HISTORY_PRIORITY_TABLE_ASSERT_SVH
`define RUNTIME_HISTORY_PRIORITY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define RHPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("runtime history table check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define RHPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("runtime history table check failed");

`endif

[src/rhpt_pkg.sv]
// Shared types, constants and helper functions of the runtime history table.
package rhpt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int KEY_W  = 64;
    localparam int DUR_W  = 32;
    localparam int BASE_W = 8;
    localparam int PRIO_W = 9;

    localparam int S_TDATA_W = ((KEY_W + DUR_W + BASE_W + 7) / 8) * 8;
    localparam int M_FIELD_W = PRIO_W + 1 + DUR_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam int REM_W = 4;

    localparam logic [DUR_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               RMIX_W      = 7;
    localparam int               RPROD_W     = 15;
    localparam logic [7:0]       REM_RECIP   = 8'd205;
    localparam int               REM_SHIFT   = 11;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic signed [PRIO_W-1:0] prio_t;

    localparam logic [DUR_W-1:0] AVG_VERY_SHORT = 32'd10;
    localparam logic [DUR_W-1:0] AVG_SHORT      = 32'd50;
    localparam logic [DUR_W-1:0] AVG_VERY_LONG  = 32'd2000;
    localparam logic [DUR_W-1:0] AVG_LONG       = 32'd500;

    localparam prio_t ADJ_BIG     = 9'sd5;
    localparam prio_t ADJ_SMALL   = 9'sd2;
    localparam prio_t ADJ_UNKNOWN = 9'sd1;
    localparam prio_t ADJ_NONE    = 9'sd0;

    typedef struct packed {
        logic load_in;
        logic compare;
        logic select;
        logic calc;
        logic div_step;
        logic div_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic record_hit;
        logic out_free;
    } status_t;

    function automatic prio_t adjust(input logic [DUR_W-1:0] avg);
        prio_t r;
        if (avg < AVG_VERY_SHORT) begin
            r = ADJ_BIG;
        end else if (avg < AVG_SHORT) begin
            r = ADJ_SMALL;
        end else if (avg > AVG_VERY_LONG) begin
            r = -ADJ_BIG;
        end else if (avg > AVG_LONG) begin
            r = -ADJ_SMALL;
        end else begin
            r = ADJ_NONE;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] lowest_set(input logic [TABLE_ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[src/runtime_history_priority_table.sv]
// Top level of the runtime history priority table.
//
// Input word (s_ channel): s_tuser is the op (0 record a duration, 1 query priority);
// s_tdata carries the task key, the run time and the starting priority. Each accepted
// word gives exactly one result word on the m_ channel: adjusted_priority, entry_found
// and average_runtime. A zero key leaves the table untouched.
// The block handles one word at a time. A query, a record of a new key and any zero
// key run through the compare, select and calc steps and then the output step before
// the next acceptance. A record of a known key splits the average update into two
// reciprocal divides by ten and a combine step, run as the divide and finish steps
// between the calc and output steps.
// The key search compares all 16 keys at once; averages sit in a registered RAM.
// The result sits in an output register, so a new word is accepted while a finished
// result still waits; when m_tready stays low the next result holds in the sequencer
// and no further word is taken until the output register frees.
// Synchronous reset (aresetn low) clears the valid bits, the replacement pointer,
// the sequencer and m_tvalid; the table then starts empty, with no clearing pass.
module runtime_history_priority_table (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // task_key[63:0], exec_time[95:64], start_prio[103:96]
    input  logic [rhpt_pkg::S_TDATA_W-1:0]   s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // adjusted_priority[8:0], entry_found[9], average_runtime[41:10], zero fill above
    output logic [rhpt_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rhpt_pkg::*;

    cmd_t             cmd;
    status_t          status;
    prio_t            out_prio;
    logic             out_found;
    logic [DUR_W-1:0] out_avg;

    rhpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rhpt_dp u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .in_op                 (s_tuser),
        .in_task_key           (s_tdata[KEY_W-1:0]),
        .in_exec_time          (s_tdata[KEY_W+DUR_W-1:KEY_W]),
        .in_start_prio         (s_tdata[KEY_W+DUR_W+BASE_W-1:KEY_W+DUR_W]),
        .m_tready              (m_tready),
        .m_tvalid              (m_tvalid),
        .out_adjusted_priority (out_prio),
        .out_entry_found       (out_found),
        .out_average_runtime   (out_avg)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_avg, out_found, out_prio};

endmodule

[src/rhpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rhpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/rhpt_ctrl.sv]
// Sequencer of the runtime history table: lookup, update, divide and output steps.
module rhpt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  rhpt_pkg::status_t status,
    output logic              s_tready,
    output rhpt_pkg::cmd_t    cmd
);
    import rhpt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_RD;
            end
            ST_RD: begin
                cmd.select = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = status.record_hit ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                cmd.div_fin = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/rhpt_dp.sv]
// Datapath of the runtime history table: key store, average RAM, divider, result words.
module rhpt_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rhpt_pkg::cmd_t                cmd,
    output rhpt_pkg::status_t             status,
    input  logic                          in_op,
    input  logic [rhpt_pkg::KEY_W-1:0]    in_task_key,
    input  logic [rhpt_pkg::DUR_W-1:0]    in_exec_time,
    input  logic [rhpt_pkg::BASE_W-1:0]   in_start_prio,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output rhpt_pkg::prio_t               out_adjusted_priority,
    output logic                          out_entry_found,
    output logic [rhpt_pkg::DUR_W-1:0]    out_average_runtime
);
    import rhpt_pkg::*;

    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DUR_W-1:0]  dur_reg;
    prio_t             base_reg;

    logic [KEY_W-1:0]          keys_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  valid_reg;
    logic [IDX_W-1:0]          ptr_reg;

    logic [TABLE_ENTRIES-1:0]  hit_vec_reg;
    logic                      zero_reg;
    logic                      hit_reg;
    logic                      full_reg;
    logic [IDX_W-1:0]          slot_reg;

    logic [DUR_W-1:0]  q_old_reg;
    logic [REM_W-1:0]  r_old_reg;
    logic [DUR_W-1:0]  q_dur_reg;
    logic [REM_W-1:0]  r_dur_reg;

    prio_t             res_prio_reg;
    logic              res_found_reg;
    logic [DUR_W-1:0]  res_avg_reg;

    logic              m_valid_reg;
    prio_t             m_prio_reg;
    logic              m_found_reg;
    logic [DUR_W-1:0]  m_avg_reg;

    logic [IDX_W-1:0]     hit_idx;
    logic [DUR_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic [DUR_W-1:0]     ram_wdata;
    logic                 new_entry;
    logic [DUR_W-1:0]     div_in, div_q, div_tenq, div_r;
    logic [2*DUR_W-1:0]   div_prod;
    logic [RMIX_W-1:0]    rem_mix;
    logic [RPROD_W-1:0]   rem_prod;
    logic [REM_W-1:0]     rem_q;
    logic [DUR_W-1:0]     blend_avg;

    assign hit_idx   = lowest_set(hit_vec_reg);
    assign new_entry = cmd.calc && !zero_reg && (op_reg == OP_RECORD) && !hit_reg;
    assign ram_we    = new_entry || cmd.div_fin;
    assign ram_wdata = cmd.div_fin ? blend_avg : dur_reg;

    assign div_in   = cmd.div_step ? dur_reg : ram_rdata;
    assign div_prod = (2*DUR_W)'(div_in) * (2*DUR_W)'(RECIP_TEN);
    assign div_q    = DUR_W'(div_prod >> RECIP_SHIFT);
    assign div_tenq = (div_q << 3) + (div_q << 1);
    assign div_r    = div_in - div_tenq;

    assign rem_mix   = (RMIX_W'(r_old_reg) << 3) - RMIX_W'(r_old_reg)
                     + (RMIX_W'(r_dur_reg) << 1) + RMIX_W'(r_dur_reg);
    assign rem_prod  = RPROD_W'(rem_mix) * RPROD_W'(REM_RECIP);
    assign rem_q     = rem_prod[RPROD_W-1:REM_SHIFT];
    assign blend_avg = (q_old_reg << 3) - q_old_reg + (q_dur_reg << 1) + q_dur_reg
                     + DUR_W'(rem_q);

    assign status.record_hit = !zero_reg && (op_reg == OP_RECORD) && hit_reg;
    assign status.out_free   = !m_valid_reg || m_tready;

    rhpt_ram #(
        .WIDTH (DUR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_avg_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (cmd.select),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (new_entry) begin
                valid_reg[slot_reg] <= 1'b1;
                if (full_reg) begin
                    ptr_reg <= (ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= in_op;
            key_reg  <= in_task_key;
            dur_reg  <= in_exec_time;
            base_reg <= {in_start_prio[BASE_W-1], in_start_prio};
        end
        if (cmd.compare) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                hit_vec_reg[i] <= valid_reg[i] && (keys_reg[i] == key_reg);
            end
            zero_reg <= (key_reg == '0);
        end
        if (cmd.select) begin
            hit_reg  <= |hit_vec_reg;
            full_reg <= &valid_reg;
            if (|hit_vec_reg) begin
                slot_reg <= hit_idx;
            end else if (&valid_reg) begin
                slot_reg <= ptr_reg;
            end else begin
                slot_reg <= lowest_set(~valid_reg);
            end
        end
        if (cmd.calc) begin
            q_old_reg <= div_q;
            r_old_reg <= div_r[REM_W-1:0];
            if (zero_reg) begin
                res_prio_reg  <= base_reg;
                res_found_reg <= 1'b0;
                res_avg_reg   <= '0;
            end else if (op_reg == OP_QUERY) begin
                if (hit_reg) begin
                    res_prio_reg  <= base_reg + adjust(ram_rdata);
                    res_found_reg <= 1'b1;
                    res_avg_reg   <= ram_rdata;
                end else begin
                    res_prio_reg  <= base_reg + ADJ_UNKNOWN;
                    res_found_reg <= 1'b0;
                    res_avg_reg   <= '0;
                end
            end else if (hit_reg) begin
                res_prio_reg  <= base_reg;
                res_found_reg <= 1'b1;
                res_avg_reg   <= '0;
            end else begin
                res_prio_reg  <= base_reg;
                res_found_reg <= 1'b0;
                res_avg_reg   <= dur_reg;
            end
        end
        if (new_entry) begin
            keys_reg[slot_reg] <= key_reg;
        end
        if (cmd.div_step) begin
            q_dur_reg <= div_q;
            r_dur_reg <= div_r[REM_W-1:0];
        end
        if (cmd.div_fin) begin
            res_avg_reg <= blend_avg;
        end
        if (cmd.out_load) begin
            m_prio_reg  <= res_prio_reg;
            m_found_reg <= res_found_reg;
            m_avg_reg   <= res_avg_reg;
        end
    end

    assign m_tvalid              = m_valid_reg;
    assign out_adjusted_priority = m_prio_reg;
    assign out_entry_found       = m_found_reg;
    assign out_average_runtime   = m_avg_reg;

endmodule

[src/rhpt_checker.sv]
// Port-level checks of the runtime history priority table, bound to the top level.
`include "runtime_history_priority_table_assert.svh"

module rhpt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rhpt_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rhpt_pkg::*;

    `RHPT_ASSERT_NEXT(a_m_valid_hold, m_tvalid && !m_tready, m_tvalid)
    `RHPT_ASSERT_NEXT(a_m_data_hold, m_tvalid && !m_tready, $stable(m_tdata))
    `RHPT_ASSERT_NEXT(a_one_word_in_flight, s_tvalid && s_tready, !s_tready)
    `RHPT_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)

endmodule

bind runtime_history_priority_table rhpt_checker u_rhpt_checker (.*);

[verif/runtime_history_priority_table_tb.sv]
// Self-checking testbench for the runtime history priority table: predicted lookups vs results.
`timescale 1ns / 1ps

module runtime_history_priority_table_tb;
    import rhpt_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_WORDS = 900;
    localparam int KEY_POOL     = 24;

    typedef struct packed {
        prio_t             prio;
        logic              found;
        logic [DUR_W-1:0]  avg;
    } lookup_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    runtime_history_priority_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // table mirror
    logic [KEY_W-1:0]  history_keys  [TABLE_ENTRIES];
    logic              history_valid [TABLE_ENTRIES];
    logic [DUR_W-1:0]  history_avg   [TABLE_ENTRIES];
    int unsigned       victim_ptr;

    lookup_t           pending_lookups [$];
    logic [KEY_W-1:0]  task_pool [KEY_POOL];
    bit                no_idle = 1'b0;
    int                mismatches = 0;
    int                results_seen = 0;
    int                record_count = 0;
    int                query_count = 0;
    int                hit_count = 0;
    int                eviction_count = 0;
    int                zero_key_count = 0;
    int                cycle_count = 0;

    function automatic prio_t runtime_bonus(input logic [DUR_W-1:0] avg);
        if (avg < AVG_VERY_SHORT) return ADJ_BIG;
        if (avg < AVG_SHORT) return ADJ_SMALL;
        if (avg > AVG_VERY_LONG) return -ADJ_BIG;
        if (avg > AVG_LONG) return -ADJ_SMALL;
        return ADJ_NONE;
    endfunction

    function automatic lookup_t apply_table_op(input logic op, input logic [KEY_W-1:0] key,
                                               input logic [DUR_W-1:0] dur,
                                               input logic [BASE_W-1:0] base);
        lookup_t     r;
        int          slot;
        logic [63:0] mix;
        slot = -1;
        r.prio = {base[BASE_W-1], base};
        r.found = 1'b0;
        r.avg = '0;
        if (key == '0) begin
            zero_key_count++;
            return r;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && history_valid[i] && history_keys[i] == key) begin
                slot = i;
            end
        end
        if (op == OP_RECORD) begin
            record_count++;
            if (slot >= 0) begin
                mix = 64'd7 * history_avg[slot] + 64'd3 * dur;
                r.found = 1'b1;
                r.avg = DUR_W'(mix / 64'd10);
                history_avg[slot] = r.avg;
                hit_count++;
            end else begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (slot < 0 && !history_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    slot = victim_ptr;
                    victim_ptr = (victim_ptr + 1 >= TABLE_ENTRIES) ? 0 : victim_ptr + 1;
                    eviction_count++;
                end
                history_keys[slot] = key;
                history_valid[slot] = 1'b1;
                history_avg[slot] = dur;
                r.avg = dur;
            end
        end else begin
            query_count++;
            if (slot >= 0) begin
                r.found = 1'b1;
                r.avg = history_avg[slot];
                r.prio = r.prio + runtime_bonus(r.avg);
                hit_count++;
            end else begin
                r.prio = r.prio + ADJ_UNKNOWN;
            end
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0) k = 64'h1;
        return k;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                             input logic [DUR_W-1:0] dur, input logic [BASE_W-1:0] base);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {base, dur, key};
        do @(posedge aclk); while (!s_tready);
        pending_lookups.push_back(apply_table_op(op, key, dur, base));
        @(negedge aclk);
    endtask

    // result side: random stall before each word, then hold ready until taken
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            repeat (gap) begin
                m_tready <= 1'b0;
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        lookup_t want;
        lookup_t got;
        logic [M_TDATA_W-M_FIELD_W-1:0] fill;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got.prio  = m_tdata[PRIO_W-1:0];
            got.found = m_tdata[PRIO_W];
            got.avg   = m_tdata[PRIO_W+DUR_W:PRIO_W+1];
            fill      = m_tdata[M_TDATA_W-1:M_FIELD_W];
            if (pending_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected result word prio=%0d found=%0b avg=%0d",
                             got.prio, got.found, got.avg);
                end
            end else begin
                want = pending_lookups.pop_front();
                if (got.prio !== want.prio || got.found !== want.found ||
                    got.avg !== want.avg || fill !== '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: word %0d want %0d/%0b/%0d got %0d/%0b/%0d fill %h",
                                 results_seen, want.prio, want.found, want.avg,
                                 got.prio, got.found, got.avg, fill);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_lookups.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_priority_bands();
        send_word(OP_RECORD, 64'h0, 32'd1234, 8'hF9);
        send_word(OP_QUERY, 64'h0, 32'hFFFF_FFFF, 8'h7F);
        send_word(OP_QUERY, 64'h0123_4567_89AB_CDEF, 32'd0, 8'h7F);
        send_word(OP_QUERY, 64'h0123_4567_89AB_CDEF, 32'd0, 8'h80);
        send_word(OP_RECORD, 64'h0123_4567_89AB_CDEF, 32'd5, 8'h11);
        send_word(OP_QUERY, 64'h0123_4567_89AB_CDEF, 32'd0, 8'h7F);
        send_word(OP_RECORD, 64'h0123_4567_89AB_CDEF, 32'd40, 8'h00);
        send_word(OP_QUERY, 64'h0123_4567_89AB_CDEF, 32'd0, 8'h00);
        send_word(OP_RECORD, 64'h0000_0000_0000_0002, 32'd10, 8'h00);
        send_word(OP_QUERY, 64'h0000_0000_0000_0002, 32'd0, 8'h05);
        send_word(OP_RECORD, 64'h8000_0000_0000_0000, 32'd50, 8'h00);
        send_word(OP_QUERY, 64'h8000_0000_0000_0000, 32'd0, 8'hFB);
        send_word(OP_RECORD, 64'h5555_5555_5555_5555, 32'd500, 8'h00);
        send_word(OP_QUERY, 64'h5555_5555_5555_5555, 32'd0, 8'h01);
        send_word(OP_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 32'd501, 8'h00);
        send_word(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 8'h80);
        send_word(OP_RECORD, 64'h0F0F_0F0F_F0F0_F0F0, 32'd2000, 8'h00);
        send_word(OP_QUERY, 64'h0F0F_0F0F_F0F0_F0F0, 32'd0, 8'h40);
        send_word(OP_RECORD, 64'hF0F0_F0F0_0F0F_0F0F, 32'd2001, 8'h00);
        send_word(OP_QUERY, 64'hF0F0_F0F0_0F0F_0F0F, 32'd0, 8'h80);
        send_word(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'h7F);
        send_word(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'h80);
        send_word(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'h00);
        send_word(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'h7F);
    endtask

    task automatic test_table_eviction();
        logic [KEY_W-1:0] keys [20];
        for (int i = 0; i < 20; i++) begin
            keys[i] = fresh_key();
            send_word(OP_RECORD, keys[i], $urandom_range(0, 3000), BASE_W'($urandom));
        end
        for (int i = 0; i < 20; i += 3) begin
            send_word(OP_QUERY, keys[i], $urandom, BASE_W'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int               pick;
        logic             op;
        logic [KEY_W-1:0] key;
        logic [DUR_W-1:0] dur;
        logic [BASE_W-1:0] base;
        for (int i = 0; i < KEY_POOL; i++) begin
            task_pool[i] = fresh_key();
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) key = '0;
            else if (pick < 13) key = fresh_key();
            else key = task_pool[$urandom_range(0, KEY_POOL - 1)];
            op = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 25) dur = $urandom_range(0, 15);
            else if (pick < 45) dur = $urandom_range(0, 60);
            else if (pick < 75) dur = $urandom_range(0, 3000);
            else if (pick < 95) dur = $urandom;
            else dur = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
            pick = $urandom_range(0, 9);
            if (pick == 0) base = 8'h80;
            else if (pick == 1) base = 8'h7F;
            else base = BASE_W'($urandom);
            send_word(op, key, dur, base);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            history_keys[i]  = '0;
            history_valid[i] = 1'b0;
            history_avg[i]   = '0;
        end
        victim_ptr = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_priority_bands();
        test_table_eviction();
        test_random_traffic();
        s_tvalid <= 1'b0;

        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d records and %0d queries plus %0d zero-key words, %0d results checked",
                 record_count, query_count, zero_key_count, results_seen);
        $display("Table hits %0d, round-robin replacements %0d, mismatches %0d",
                 hit_count, eviction_count, mismatches);
        if (mismatches == 0 && pending_lookups.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
